// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- sv/fse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fse_pkg
// Shared types and constants for the frontier state expansion block.
// ----------------------------------------------------------------------------
package fse_pkg;

    localparam int KEY_W       = 64;   // packed key width
    localparam int RES_W       = 31;   // residue / modulus width
    localparam int CC_W        = 4;    // color count width
    localparam int MASK_FIELDS = 16;   // fields reachable by the masks
    localparam int DATA_W      = 96;   // key + residue, byte padded
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CC_W-1:0]  RESET_COLOR_COUNT = 4'd15;
    localparam logic [RES_W-1:0] RESET_MODULUS     = 31'h7FFF_FFFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRICT_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENTERS_LIVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOD,
        ST_EMIT_ONE,
        ST_EMIT_LIVE
    } fse_state_t;

endpackage : fse_pkg
`default_nettype wire

// ----- sv/frontier_state_expansion.sv -----
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// frontier_state_expansion
// Expands one DP frontier state into its successor states.
// ----------------------------------------------------------------------------
// One word in on s_ carries a state (key + residue). A small sequencer walks
// the key one field per cycle through a shared extract/compare/pack unit:
// a scan over min(KEY_FIELDS,16) fields finds the lower color bound (max
// parent field, +1 when strict, at least 1) and packs the kept fields, then
// a decide step follows. If the bound exceeds color_count nothing goes out.
// In live mode one word per color from the bound to color_count follows,
// one per cycle while m_ is not stalled, tlast on the final color. Otherwise
// residue*(color count span) is reduced by a bit-serial shift/subtract unit
// and a single word (tlast set) goes out. A word waits in its emit state while
// the output register is still held by m_. s_tready is high only while the
// sequencer is idle, and the sequencer returns to idle only once the last
// word of an item is loaded (or, without successor, after the decide step),
// so a new word is taken only once the last one is through. The output
// register lets a new word be taken while the last result still waits on m_.
// Configuration writes are taken at any time but must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module frontier_state_expansion #(
    parameter int KEY_FIELDS = 16,   // 1..32
    parameter int FIELD_BITS = 4     // 2..6
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // configuration write port
    input  wire                           cfg_wr_en,
    input  wire [fse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [fse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [fse_pkg::DATA_W-1:0]     s_tdata,   // [63:0] state_key, [94:64] residue
    // result stream
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [fse_pkg::DATA_W-1:0]    m_tdata,   // [63:0] next_key, [94:64] next_residue
    output logic                          m_tlast    // last_of_run
);
    import fse_pkg::*;

    localparam int SCAN_FIELDS = (KEY_FIELDS < MASK_FIELDS) ? KEY_FIELDS : MASK_FIELDS;
    localparam int SCAN_CNT_W  = (SCAN_FIELDS > 1) ? $clog2(SCAN_FIELDS) : 1;
    localparam int LOW_W       = FIELD_BITS + 1;             // field value + strict step
    localparam int CMP_W       = (LOW_W > CC_W) ? LOW_W : CC_W;
    localparam int OFS_W       = $clog2(MASK_FIELDS * FIELD_BITS + 1);
    localparam int PROD_W      = RES_W + CC_W;
    localparam int MOD_CNT_W   = $clog2(PROD_W);

    // ---------------- configuration registers ----------------
    logic [CC_W-1:0]        color_count_reg;
    logic                   strict_mode_reg;
    logic [MASK_FIELDS-1:0] parent_mask_reg;
    logic [MASK_FIELDS-1:0] keep_mask_reg;
    logic                   enters_live_reg;
    logic [RES_W-1:0]       modulus_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_count_reg <= RESET_COLOR_COUNT;
            strict_mode_reg <= 1'b0;
            parent_mask_reg <= '0;
            keep_mask_reg   <= '0;
            enters_live_reg <= 1'b0;
            modulus_reg     <= RESET_MODULUS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COLOR_COUNT: color_count_reg <= cfg_wdata[CC_W-1:0];
                REG_STRICT_MODE: strict_mode_reg <= cfg_wdata[0];
                REG_PARENT_MASK: parent_mask_reg <= cfg_wdata[MASK_FIELDS-1:0];
                REG_KEEP_MASK:   keep_mask_reg   <= cfg_wdata[MASK_FIELDS-1:0];
                REG_ENTERS_LIVE: enters_live_reg <= cfg_wdata[0];
                REG_MODULUS:     modulus_reg     <= cfg_wdata[RES_W-1:0];
                default: ;      // writes beyond the list are ignored
            endcase
        end
    end

    // ---------------- datapath / sequencer registers ----------------
    fse_state_t             state_reg,    state_next;
    logic [KEY_W-1:0]       key_sh_reg,   key_sh_next;    // key, shifted one field per scan
    logic [MASK_FIELDS-1:0] par_sh_reg,   par_sh_next;
    logic [MASK_FIELDS-1:0] keep_sh_reg,  keep_sh_next;
    logic [RES_W-1:0]       res_reg,      res_next;
    logic [LOW_W-1:0]       lower_reg,    lower_next;
    logic [KEY_W-1:0]       base_reg,     base_next;      // packed kept fields
    logic [OFS_W-1:0]       ofs_reg,      ofs_next;       // bit offset of next packed field
    logic [SCAN_CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [PROD_W-1:0]      prod_reg,     prod_next;
    logic [RES_W-1:0]       rem_reg,      rem_next;
    logic [MOD_CNT_W-1:0]   mod_cnt_reg,  mod_cnt_next;
    logic [CC_W-1:0]        color_reg,    color_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]      m_tdata_reg,  m_tdata_next;
    logic                   m_tlast_reg,  m_tlast_next;

    // shared unit signals
    logic [FIELD_BITS-1:0]  field;
    logic [LOW_W-1:0]       cand;
    logic [CC_W-1:0]        span;
    logic [RES_W:0]         trial;
    logic [KEY_W-1:0]       col_field;
    logic                   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        state_next    = state_reg;
        key_sh_next   = key_sh_reg;
        par_sh_next   = par_sh_reg;
        keep_sh_next  = keep_sh_reg;
        res_next      = res_reg;
        lower_next    = lower_reg;
        base_next     = base_reg;
        ofs_next      = ofs_reg;
        scan_cnt_next = scan_cnt_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        mod_cnt_next  = mod_cnt_reg;
        color_next    = color_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        field     = key_sh_reg[FIELD_BITS-1:0];
        cand      = LOW_W'(field) + LOW_W'(strict_mode_reg);
        span      = color_count_reg - CC_W'(lower_reg) + CC_W'(1);
        trial     = {rem_reg, prod_reg[PROD_W-1]};
        col_field = KEY_W'(FIELD_BITS'(color_reg));

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_sh_next   = s_tdata[KEY_W-1:0];
                    res_next      = s_tdata[KEY_W +: RES_W];
                    par_sh_next   = parent_mask_reg;
                    keep_sh_next  = keep_mask_reg;
                    lower_next    = LOW_W'(1);
                    base_next     = '0;
                    ofs_next      = '0;
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // one field per cycle: parent max and keep packing
                if (par_sh_reg[0] && (cand > lower_reg)) begin
                    lower_next = cand;
                end
                if (keep_sh_reg[0]) begin
                    // offsets at or past the key width shift out to zero
                    base_next = base_reg | (KEY_W'(field) << ofs_reg);
                    ofs_next  = ofs_reg + OFS_W'(FIELD_BITS);
                end
                key_sh_next   = key_sh_reg >> FIELD_BITS;
                par_sh_next   = par_sh_reg >> 1;
                keep_sh_next  = keep_sh_reg >> 1;
                scan_cnt_next = scan_cnt_reg + SCAN_CNT_W'(1);
                if (scan_cnt_reg == SCAN_CNT_W'(SCAN_FIELDS - 1)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (CMP_W'(lower_reg) > CMP_W'(color_count_reg)) begin
                    state_next = ST_IDLE;           // no successor
                end else if (enters_live_reg) begin
                    color_next = CC_W'(lower_reg);
                    state_next = ST_EMIT_LIVE;
                end else begin
                    prod_next    = PROD_W'(res_reg) * PROD_W'(span);
                    rem_next     = '0;
                    mod_cnt_next = '0;
                    state_next   = ST_MOD;
                end
            end
            ST_MOD: begin
                // restoring reduction, one product bit per cycle
                if (trial >= {1'b0, modulus_reg}) begin
                    rem_next = RES_W'(trial - {1'b0, modulus_reg});
                end else begin
                    rem_next = RES_W'(trial);
                end
                prod_next    = prod_reg << 1;
                mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
                if (mod_cnt_reg == MOD_CNT_W'(PROD_W - 1)) begin
                    state_next = ST_EMIT_ONE;
                end
            end
            ST_EMIT_ONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = {1'b0, ((modulus_reg == '0) ? RES_W'(0) : rem_reg),
                                     base_reg};
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_LIVE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = (color_reg == color_count_reg);
                    m_tdata_next  = {1'b0, res_reg, base_reg | (col_field << ofs_reg)};
                    color_next    = color_reg + CC_W'(1);
                    if (color_reg == color_count_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_sh_reg   <= key_sh_next;
        par_sh_reg   <= par_sh_next;
        keep_sh_reg  <= keep_sh_next;
        res_reg      <= res_next;
        lower_reg    <= lower_next;
        base_reg     <= base_next;
        ofs_reg      <= ofs_next;
        scan_cnt_reg <= scan_cnt_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        mod_cnt_reg  <= mod_cnt_next;
        color_reg    <= color_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    // ---------------- assertions ----------------
    // an accepted word always starts a field scan
    `FSE_ASSERT_NEXT(a_accept_scans, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_SCAN)
    // live colors stay inside [1, color_count]
    `FSE_ASSERT_NOW(a_color_range, aclk, aresetn, state_reg == ST_EMIT_LIVE, (color_reg <= color_count_reg) && (color_reg != '0))
    // partial remainder stays reduced below a nonzero modulus
    `FSE_ASSERT_NOW(a_rem_reduced, aclk, aresetn, (state_reg == ST_MOD) && (modulus_reg != '0), rem_reg < modulus_reg)

endmodule : frontier_state_expansion
`default_nettype wire

// ----- verif/frontier_state_expansion_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frontier_state_expansion_tb
// Self-checking bench for the frontier state expansion block.
// ----------------------------------------------------------------------------
// States go in on s_ from a queue and are predicted as they are taken. Each
// successor word seen on m_ is checked against the oldest prediction. Config
// only changes while the block is drained. A directed set covers the mask,
// mode and modulus corners. Random phases follow, each with a fresh config.
// The sender runs in bursts, and the receiver switches between stall styles.
// One long receiver hold backs up the block.
// ----------------------------------------------------------------------------
module frontier_state_expansion_tb;
    import fse_pkg::*;

    localparam int NFIELDS       = 16;
    localparam int FBITS         = 4;
    localparam int SEL_FIELDS    = (NFIELDS < MASK_FIELDS) ? NFIELDS : MASK_FIELDS;
    localparam int SETTLE_CYCLES = 80;      // room for the scan, decide and modular reduce of a last state
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_PHASES   = 9;
    localparam int RAND_ITEMS    = 28;
    localparam int PAD_W         = DATA_W - KEY_W - RES_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [RES_W-1:0] res;
    } dp_state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [RES_W-1:0] res;
        logic             run_end;
    } successor_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_QUARTER,
        READY_MOSTLY
    } ready_style_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;   // [63:0] state_key, [94:64] residue
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;          // [63:0] next_key, [94:64] next_residue
    logic                  m_tlast;          // last_of_run

    frontier_state_expansion #(
        .KEY_FIELDS (NFIELDS),
        .FIELD_BITS (FBITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // bench copy of the config registers (reset values)
    // ------------------------------------------------------------------------
    logic [CC_W-1:0]  cfg_colors  = RESET_COLOR_COUNT;
    logic             cfg_strict  = 1'b0;
    logic [15:0]      cfg_parents = '0;
    logic [15:0]      cfg_keeps   = '0;
    logic             cfg_live    = 1'b0;
    logic [RES_W-1:0] cfg_mod     = RESET_MODULUS;

    dp_state_t  pending_states[$];
    successor_t expected_successors[$];

    logic [31:0] cycle_cnt    = '0;
    int          err_cnt      = 0;
    int          states_taken = 0;
    int          dead_states  = 0;   // states with no successor
    int          words_seen   = 0;
    int          phases_run   = 0;
    logic        hold_req     = 1'b0;

    // ------------------------------------------------------------------------
    // successor prediction
    // ------------------------------------------------------------------------
    function automatic logic [FBITS-1:0] field_at(logic [KEY_W-1:0] key, int pos);
        if (pos * FBITS >= KEY_W)
            return '0;
        return FBITS'(key >> (pos * FBITS));
    endfunction

    // fields starting at or past bit 64 fall off the key
    function automatic logic [KEY_W-1:0] place_at(logic [FBITS-1:0] v, int pos);
        if (pos * FBITS >= KEY_W)
            return '0;
        return KEY_W'(v) << (pos * FBITS);
    endfunction

    // new prediction goes to the tail
    function automatic void queue_successor(successor_t nx);
        expected_successors.insert(expected_successors.size(), nx);
    endfunction

    function automatic void expand_state(dp_state_t st);
        int               bound;
        int               cand;
        int               kept;
        int               p;
        int               c;
        logic [KEY_W-1:0] base;
        logic [63:0]      prod;
        successor_t       nx;
        bound = 1;
        for (p = 0; p < SEL_FIELDS; p++) begin
            if (cfg_parents[p]) begin
                cand = int'(field_at(st.key, p)) + int'(cfg_strict);
                if (cand > bound)
                    bound = cand;
            end
        end
        if (bound > int'(cfg_colors)) begin
            dead_states++;
            return;
        end
        base = '0;
        kept = 0;
        for (p = 0; p < SEL_FIELDS; p++) begin
            if (cfg_keeps[p]) begin
                base |= place_at(field_at(st.key, p), kept);
                kept++;
            end
        end
        if (!cfg_live) begin
            // fold the color span into the residue
            prod = 64'(st.res) * 64'(int'(cfg_colors) - bound + 1);
            nx.key     = base;
            nx.res     = (cfg_mod == '0) ? '0 : RES_W'(prod % 64'(cfg_mod));
            nx.run_end = 1'b1;
            queue_successor(nx);
        end else begin
            // one word per color, residue passed through as given
            for (c = bound; c <= int'(cfg_colors); c++) begin
                nx.key     = base | place_at(FBITS'(c), kept);
                nx.res     = st.res;
                nx.run_end = (c == int'(cfg_colors));
                queue_successor(nx);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // sender: bursts of random length, random gaps in between
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        dp_state_t nxt;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expand_state(dp_state_t'{s_tdata[KEY_W-1:0], s_tdata[KEY_W +: RES_W]});
                states_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_states.size() > 0) begin
                    nxt = pending_states.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{PAD_W{1'b0}}, nxt.res, nxt.key};
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stall style redrawn at random; one long hold
    // ------------------------------------------------------------------------
    ready_style_t ready_style  = READY_ALWAYS;
    int           pattern_left = 0;
    int           hold_left    = 0;
    logic         hold_done    = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                ready_style  <= ready_style_t'($urandom_range(0, 3));
                pattern_left <= $urandom_range(20, 80);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (ready_style)
                READY_ALWAYS:  m_tready <= 1'b1;
                READY_COIN:    m_tready <= 1'($urandom_range(0, 1));
                READY_QUARTER: m_tready <= (cycle_cnt[1:0] == 2'b11);
                default:       m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // result checking against the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void flag_mismatch(string fld, logic [63:0] want, logic [63:0] got);
        err_cnt++;
        if (err_cnt <= 40)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
    endfunction

    always @(posedge aclk) begin
        successor_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (expected_successors.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 40)
                    $display("%0t: unexpected word, expected none, actual key %h res %h",
                             $time, m_tdata[KEY_W-1:0], m_tdata[KEY_W +: RES_W]);
            end else begin
                want = expected_successors.pop_front();
                if (m_tdata[KEY_W-1:0] !== want.key)
                    flag_mismatch("next_key", want.key, m_tdata[KEY_W-1:0]);
                if (m_tdata[KEY_W +: RES_W] !== want.res)
                    flag_mismatch("next_residue", 64'(want.res), 64'(m_tdata[KEY_W +: RES_W]));
                if (m_tlast !== want.run_end)
                    flag_mismatch("last_of_run", 64'(want.run_end), 64'(m_tlast));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequencing helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_COLOR_COUNT: cfg_colors  = val[CC_W-1:0];
            REG_STRICT_MODE: cfg_strict  = val[0];
            REG_PARENT_MASK: cfg_parents = val[15:0];
            REG_KEEP_MASK:   cfg_keeps   = val[15:0];
            REG_ENTERS_LIVE: cfg_live    = val[0];
            REG_MODULUS:     cfg_mod     = val[RES_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(int colors, bit strict, logic [15:0] parents,
                              logic [15:0] keeps, bit live, logic [RES_W-1:0] modv);
        write_reg(REG_COLOR_COUNT, CFG_DATA_W'(colors));
        write_reg(REG_STRICT_MODE, CFG_DATA_W'(strict));
        write_reg(REG_PARENT_MASK, CFG_DATA_W'(parents));
        write_reg(REG_KEEP_MASK,   CFG_DATA_W'(keeps));
        write_reg(REG_ENTERS_LIVE, CFG_DATA_W'(live));
        write_reg(REG_MODULUS,     CFG_DATA_W'(modv));
        phases_run++;
        @(negedge aclk);
    endtask

    task automatic offer(logic [KEY_W-1:0] key, logic [RES_W-1:0] res);
        pending_states.insert(pending_states.size(), dp_state_t'{key, res});
    endtask

    // all words out, then room for a trailing state that yields nothing
    task automatic drain();
        while (pending_states.size() != 0 || s_tvalid || expected_successors.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly fields within the color range so that states survive the bound
    function automatic logic [KEY_W-1:0] draw_key();
        logic [KEY_W-1:0] k;
        int               p;
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom};
        k = '0;
        for (p = 0; p * FBITS < KEY_W; p++) begin
            if ($urandom_range(0, 4) == 0)
                k[p*FBITS +: FBITS] = FBITS'($urandom);
            else
                k[p*FBITS +: FBITS] = FBITS'($urandom_range(0, int'(cfg_colors)));
        end
        return k;
    endfunction

    function automatic logic [RES_W-1:0] draw_residue();
        case ($urandom_range(0, 3))
            0:       return RES_W'($urandom_range(0, 15));
            1:       return RES_W'($urandom_range(0, 2147483646));
            2:       return RES_W'($urandom_range(2147483000, 2147483646));
            default: return RES_W'($urandom_range(0, 2147483646));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int               ph;
        int               i;
        int               colors;
        logic [15:0]      parents;
        logic [15:0]      keeps;
        logic [RES_W-1:0] modv;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset config: bound 1, residue times 15
        offer(64'h0, 31'd0);
        offer(64'hFFFF_FFFF_FFFF_FFFF, 31'd2147483646);
        offer(64'h0123_4567_89AB_CDEF, 31'd1);
        drain();

        // all fields kept: appended color lands past bit 63 and is dropped;
        // all-ones parents under strict push the bound past the count
        set_config(15, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, RESET_MODULUS);
        offer(64'h0, 31'd5);
        offer(64'hFFFF_FFFF_FFFF_FFFF, 31'd7);
        offer(64'hEEEE_EEEE_EEEE_EEEE, 31'd2147483646);
        drain();

        // zero color count never expands
        set_config(0, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 31'd97);
        offer(64'h1234_5678_9ABC_DEF0, 31'd3);
        drain();

        // single color, residue above the modulus passes through unreduced
        set_config(1, 1'b0, 16'h8001, 16'h5555, 1'b1, 31'd3);
        offer(64'h0, 31'd2147483646);
        offer(64'h1000_0000_0000_0001, 31'd10);
        offer(64'h0000_0000_0000_0002, 31'd4);
        drain();

        // modulus zero folds to zero
        set_config(15, 1'b0, 16'h0001, 16'hFFFE, 1'b0, 31'd0);
        offer(64'h0000_0000_0000_0005, 31'd12345);
        offer(64'hA5A5_A5A5_A5A5_A5AF, 31'd2147483646);
        drain();

        // modulus one
        set_config(7, 1'b1, 16'h00F0, 16'h00FF, 1'b0, 31'd1);
        offer(64'h0000_0000_0321_7654, 31'd999);
        drain();

        // smallest prime, top field as sole parent and sole survivor
        set_config(15, 1'b1, 16'h8000, 16'h8000, 1'b0, 31'd2);
        offer(64'hE000_0000_0000_0000, 31'd2147483645);
        offer(64'h3000_0000_0000_0000, 31'd8);
        drain();

        // nothing kept: color sits in field 0
        set_config(15, 1'b0, 16'hFFFF, 16'h0000, 1'b1, RESET_MODULUS);
        offer(64'h0, 31'd77);
        drain();

        set_config(9, 1'b1, 16'h0F0F, 16'hA5A5, 1'b1, 31'd1000003);
        for (i = 0; i < 3; i++)
            offer(draw_key(), draw_residue());
        drain();

        // random phases
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       colors = 15;
                1:       colors = 1;
                default: colors = $urandom_range(1, 15);
            endcase
            case ($urandom_range(0, 4))
                0:       parents = 16'h0000;
                1:       parents = 16'hFFFF;
                2:       parents = 16'($urandom);
                default: parents = 16'($urandom & $urandom & $urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       keeps = 16'hFFFF;
                1:       keeps = 16'h0000;
                default: keeps = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       modv = 31'd2;
                1:       modv = RESET_MODULUS;
                2:       modv = RES_W'($urandom_range(3, 1000));
                default: modv = RES_W'($urandom_range(2, 2147483647));
            endcase
            if (ph == 1) begin
                // long run lengths while the receiver holds off
                set_config(15, 1'b0, 16'h0000, keeps, 1'b1, modv);
                hold_req <= 1'b1;
            end else begin
                set_config(colors, 1'($urandom), parents, keeps, 1'($urandom), modv);
            end
            for (i = 0; i < RAND_ITEMS; i++)
                offer(draw_key(), draw_residue());
            drain();
        end

        $display("Covered %0d states over %0d configurations: %0d successor words checked,",
                 states_taken, phases_run + 1, words_seen);
        $display("%0d states without successor, one long output hold.", dead_states);
        if (err_cnt == 0 && expected_successors.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule : frontier_state_expansion_tb
`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/fse_pkg.sv
sv/frontier_state_expansion.sv
verif/frontier_state_expansion_tb.sv
